/* hw/rtl/lcff_pkg.sv */
// Shared types and constants for the LED chain frame filler.
package lcff_pkg;

   // Command codes carried in the request.
   localparam logic [1:0] CMD_SET_COLOR  = 2'd0;
   localparam logic [1:0] CMD_SET_ENABLE = 2'd1;
   localparam logic [1:0] CMD_REFRESH    = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [1:0] CSR_CHAIN      = 2'd1;
   localparam logic [1:0] CSR_SKIP_FIRST = 2'd2;
   localparam logic [1:0] CSR_SKIP_LAST  = 2'd3;

   localparam int CSR_W = 8;
   localparam int LEN_W = 7;
   localparam int PCT_W = 7;

   localparam logic [7:0] BRIGHT_RESET = 8'd100;
   localparam logic [7:0] BRIGHT_MAX   = 8'd100;
   localparam logic [6:0] CHAIN_RESET  = 7'd64;

   // floor(x / 100) for x <= 25500 equals (x * 5243) >> 19.
   localparam int          PROD_W     = 15;
   localparam int          RECIP_W    = 13;
   localparam logic [12:0] RECIP_100  = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          WIDE_W     = PROD_W + RECIP_W;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       enable_value;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic        last_pixel;
   } rsp_type;

   // One frame job handed from the front to the back.
   typedef struct packed {
      logic       zero_frame;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } job_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   typedef struct packed {
      logic [PCT_W-1:0] bright;
      logic [LEN_W-1:0] chain_count;
      logic [LEN_W-1:0] skip_first;
      logic [LEN_W-1:0] skip_last;
   } cfg_type;

endpackage

/* hw/rtl/lcff_front.sv */
// Command front end: holds enable and color state and queues frame jobs.
module lcff_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lcff_pkg::req_type         req_data,
   input  logic [lcff_pkg::PCT_W-1:0] bright,
   input  lcff_pkg::queue_status_type q_status,
   output logic                      q_push,
   output lcff_pkg::job_type         q_job
);
   import lcff_pkg::*;

   logic       enabled_ff, enabled_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic       accept;
   logic       bright_on;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign bright_on = (bright != '0);

   always_comb begin
      enabled_in = enabled_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      q_push     = 1'b0;
      q_job      = '{zero_frame: 1'b0, red: red_ff, green: green_ff, blue: blue_ff};
      if (accept) begin
         unique case (req_data.command)
            CMD_SET_COLOR: begin
               red_in      = req_data.red;
               green_in    = req_data.green;
               blue_in     = req_data.blue;
               q_job.red   = req_data.red;
               q_job.green = req_data.green;
               q_job.blue  = req_data.blue;
               q_push      = enabled_ff && bright_on;
            end
            CMD_SET_ENABLE: begin
               enabled_in = req_data.enable_value;
               if (enabled_ff && !req_data.enable_value) begin
                  q_job.zero_frame = 1'b1;
                  q_push           = 1'b1;
               end else if (!enabled_ff && req_data.enable_value) begin
                  q_push = bright_on;
               end
            end
            CMD_REFRESH: begin
               q_push = enabled_ff && bright_on;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         red_ff     <= '0;
         green_ff   <= '0;
         blue_ff    <= '0;
      end else begin
         enabled_ff <= enabled_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
      end
   end

endmodule

/* hw/rtl/lcff_queue.sv */
// Small job queue between the command front end and the frame generator.
module lcff_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lcff_pkg::job_type          push_job,
   input  logic                       pop,
   output lcff_pkg::job_type          head_job,
   output lcff_pkg::queue_status_type status
);
   import lcff_pkg::*;

   job_type            entries_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QDEPTH));
   assign status.valid = (count_ff != '0);
   assign head_job     = entries_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      next_ptr = (ptr == QPTR_W'(QDEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/lcff_back.sv */
// Frame generator: scales the color and streams one word per LED.
module lcff_back #(
   parameter int MAX_CHAIN = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lcff_pkg::queue_status_type q_status,
   input  lcff_pkg::job_type          q_job,
   output logic                       q_pop,
   input  lcff_pkg::cfg_type          cfg,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lcff_pkg::rsp_type          rsp_data
);
   import lcff_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   localparam logic [LEN_W-1:0] MAX_N = LEN_W'(MAX_CHAIN);

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [PROD_W-1:0]  prod_r_ff, prod_g_ff, prod_b_ff;
   logic [31:0]        word_ff, word_in;
   logic [LEN_W-1:0]   n_ff, n_in;
   logic [LEN_W-1:0]   head_ff, head_in;
   logic [LEN_W-1:0]   lim_ff, lim_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [LEN_W:0]     skip_sum;
   logic               use_skips;
   logic               out_free;
   logic               is_last;
   logic               dark;
   logic [WIDE_W-1:0]  wide_r, wide_g, wide_b;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_status.valid;
   assign is_last   = (idx_ff == n_ff - 1'b1);
   assign dark      = (idx_ff < head_ff) || (idx_ff >= lim_ff);

   assign wide_r = WIDE_W'(prod_r_ff) * WIDE_W'(RECIP_100);
   assign wide_g = WIDE_W'(prod_g_ff) * WIDE_W'(RECIP_100);
   assign wide_b = WIDE_W'(prod_b_ff) * WIDE_W'(RECIP_100);

   always_comb begin
      if (cfg.chain_count == '0) begin
         n_in = LEN_W'(1);
      end else if (cfg.chain_count > MAX_N) begin
         n_in = MAX_N;
      end else begin
         n_in = cfg.chain_count;
      end
      skip_sum  = {1'b0, cfg.skip_first} + {1'b0, cfg.skip_last};
      use_skips = (skip_sum < {1'b0, n_in});
      head_in   = use_skips ? cfg.skip_first : '0;
      lim_in    = use_skips ? n_in - cfg.skip_last : n_in;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.valid) begin
               job_in   = q_job;
               idx_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (job_ff.zero_frame) begin
               word_in = '0;
            end else begin
               word_in = {wide_r[RECIP_SHIFT +: 8], wide_g[RECIP_SHIFT +: 8],
                          wide_b[RECIP_SHIFT +: 8], 8'h00};
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.pixel_word = dark ? '0 : word_ff;
               rsp_in.last_pixel = is_last;
               idx_in            = idx_ff + 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Frame geometry is latched when a job is taken from the queue.
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      word_ff <= word_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
      if (q_pop) begin
         n_ff    <= n_in;
         head_ff <= head_in;
         lim_ff  <= lim_in;
      end
      prod_r_ff <= PROD_W'(job_ff.red * cfg.bright);
      prod_g_ff <= PROD_W'(job_ff.green * cfg.bright);
      prod_b_ff <= PROD_W'(job_ff.blue * cfg.bright);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/led_chain_frame_fill.sv */
// LED chain frame filler top level: register file, front end, queue and frame generator.
//
// Commands (set color, set enable, refresh) are taken at up to one per cycle by the
// front end while the queue is not full; it updates the stored color and enable flag
// and places any frame that is due in a two-entry queue. The frame generator takes a
// job (dequeue), applies the brightness multiply, divides by 100 through a reciprocal
// multiply and then streams one word per LED; it takes no new job until the last word
// of a frame has been issued. Commands that cause no frame are accepted while a frame
// is still streaming, unless the queue is full. Configuration registers take effect
// for frames that start after they are written.
module led_chain_frame_fill #(
   parameter int MAX_CHAIN = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lcff_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lcff_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [lcff_pkg::CSR_W-1:0]  csr_wdata
);
   import lcff_pkg::*;

   logic [7:0]       brightness_ff;
   logic [LEN_W-1:0] chain_count_ff;
   logic [LEN_W-1:0] skip_first_ff;
   logic [LEN_W-1:0] skip_last_ff;
   cfg_type          cfg;
   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             q_push;
   logic             q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= BRIGHT_RESET;
         chain_count_ff <= CHAIN_RESET;
         skip_first_ff  <= '0;
         skip_last_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BRIGHTNESS: brightness_ff  <= csr_wdata;
            CSR_CHAIN:      chain_count_ff <= csr_wdata[LEN_W-1:0];
            CSR_SKIP_FIRST: skip_first_ff  <= csr_wdata[LEN_W-1:0];
            CSR_SKIP_LAST:  skip_last_ff   <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.bright      = (brightness_ff > BRIGHT_MAX) ? PCT_W'(BRIGHT_MAX)
                                                     : brightness_ff[PCT_W-1:0];
      cfg.chain_count = chain_count_ff;
      cfg.skip_first  = skip_first_ff;
      cfg.skip_last   = skip_last_ff;
   end

   lcff_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .bright    (cfg.bright),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   lcff_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   lcff_back #(
      .MAX_CHAIN (MAX_CHAIN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The front end must never push into a full queue.
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_status.full))
      else $error("job pushed into a full queue");

   // Every LED word leaves the low byte clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pixel_word[7:0] == 8'h00))
      else $error("pixel word has a nonzero low byte");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A job is only taken when the queue holds one.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_status.valid)
      else $error("job taken from an empty queue");

endmodule

/* bench/tb_led_chain_frame_fill.sv */
// Self-checking testbench for the LED chain frame filler: directed cases, then random phases.
`timescale 1ns / 1ps

module tb_led_chain_frame_fill;
   import lcff_pkg::*;

   localparam int MAX_CHAIN = 64;
   localparam logic [1:0] CMD_RESERVED = 2'd3;
   // Cycles to let a command that makes no words drain before touching the registers.
   localparam int SETTLE_CYCLES = 32;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   led_chain_frame_fill #(.MAX_CHAIN(MAX_CHAIN)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Register copies and chain state as the block should hold them.
   logic [7:0] cfg_bright;
   logic [6:0] cfg_chain;
   logic [6:0] cfg_skip_first;
   logic [6:0] cfg_skip_last;
   logic       lit;
   logic [7:0] color_r;
   logic [7:0] color_g;
   logic [7:0] color_b;

   rsp_type words_due[$];
   rsp_type want_word;

   int mismatches = 0;
   int commands_sent = 0;
   int words_seen = 0;
   int frames_seen = 0;
   int settings_used = 0;
   bit idle_on = 0;
   bit stall_on = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void note_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
   endfunction

   function automatic logic [7:0] scale_level(input logic [7:0] level, input int unsigned pct);
      int unsigned prod;
      prod = 32'(level) * pct;
      return 8'(prod / 100);
   endfunction

   function automatic void push_frame(input logic [31:0] word, input bit use_skips);
      int unsigned n;
      int unsigned head;
      int unsigned tail;
      rsp_type w;
      n = (cfg_chain == 0) ? 1 : ((cfg_chain > MAX_CHAIN) ? MAX_CHAIN : 32'(cfg_chain));
      head = 0;
      tail = 0;
      if (use_skips && (32'(cfg_skip_first) + 32'(cfg_skip_last) < n)) begin
         head = 32'(cfg_skip_first);
         tail = 32'(cfg_skip_last);
      end
      for (int unsigned i = 0; i < n; i++) begin
         w.pixel_word = ((i < head) || (i >= n - tail)) ? 32'd0 : word;
         w.last_pixel = (i + 1 == n);
         words_due.push_back(w);
      end
   endfunction

   function automatic void push_color_frame();
      int unsigned pct;
      pct = (cfg_bright > BRIGHT_MAX) ? 32'(BRIGHT_MAX) : 32'(cfg_bright);
      if (!lit || pct == 0) return;
      push_frame({scale_level(color_r, pct), scale_level(color_g, pct),
                  scale_level(color_b, pct), 8'h00}, 1'b1);
   endfunction

   function automatic void apply_command(input req_type item);
      case (item.command)
         CMD_SET_COLOR: begin
            color_r = item.red;
            color_g = item.green;
            color_b = item.blue;
            push_color_frame();
         end
         CMD_SET_ENABLE: begin
            if (!item.enable_value && lit) begin
               lit = 1'b0;
               push_frame(32'd0, 1'b0);
            end else if (item.enable_value && !lit) begin
               lit = 1'b1;
               push_color_frame();
            end
         end
         CMD_REFRESH: begin
            push_color_frame();
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void apply_write(input logic [1:0] index, input logic [7:0] value);
      case (index)
         CSR_BRIGHTNESS: cfg_bright = value;
         CSR_CHAIN:      cfg_chain = value[6:0];
         CSR_SKIP_FIRST: cfg_skip_first = value[6:0];
         CSR_SKIP_LAST:  cfg_skip_last = value[6:0];
         default: begin
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_cmd(input logic [1:0] cmd, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic en);
      req_type item;
      item.command = cmd;
      item.red = r;
      item.green = g;
      item.blue = b;
      item.enable_value = en;
      return item;
   endfunction

   // Checks every result transaction against the oldest expected word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (rsp_data.last_pixel) frames_seen++;
         if (words_due.size() == 0) begin
            note_error($sformatf("unexpected word %h last %b",
                                 rsp_data.pixel_word, rsp_data.last_pixel));
         end else begin
            want_word = words_due.pop_front();
            if (rsp_data.pixel_word !== want_word.pixel_word)
               note_error($sformatf("pixel_word expected %h actual %h",
                                    want_word.pixel_word, rsp_data.pixel_word));
            if (rsp_data.last_pixel !== want_word.last_pixel)
               note_error($sformatf("last_pixel expected %b actual %b",
                                    want_word.last_pixel, rsp_data.last_pixel));
         end
      end
   end

   // Receiver back-pressure.
   initial begin
      int len;
      rsp_ready <= 1'b1;
      forever begin
         @(negedge clock);
         if (stall_on && $urandom_range(0, 99) < 20) begin
            rsp_ready <= 1'b0;
            len = pick_gap();
            if (len == 0) len = 1;
            repeat (len - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_cmd(input req_type item);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_command(item);
      commands_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_write(index, value);
   endtask

   task automatic set_config(input logic [7:0] bright, input logic [7:0] chain,
                             input logic [7:0] skip_first, input logic [7:0] skip_last);
      settle();
      write_reg(CSR_BRIGHTNESS, bright);
      write_reg(CSR_CHAIN, chain);
      write_reg(CSR_SKIP_FIRST, skip_first);
      write_reg(CSR_SKIP_LAST, skip_last);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic test_reset_state();
      // The stored color starts black and the chain starts lit at full length.
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));
      send_cmd(make_cmd(CMD_SET_COLOR, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_cmd(make_cmd(CMD_SET_COLOR, 8'h80, 8'h01, 8'h7F, 1'b0));
   endtask

   task automatic test_brightness();
      set_config(8'd0, 8'd4, 8'd0, 8'd0);
      send_cmd(make_cmd(CMD_SET_COLOR, 8'hFF, 8'h80, 8'h01, 1'b0));
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));
      set_config(8'd255, 8'd4, 8'd0, 8'd0);
      send_cmd(make_cmd(CMD_SET_COLOR, 8'hFF, 8'hC3, 8'h3C, 1'b0));
      set_config(8'd1, 8'd3, 8'd0, 8'd0);
      send_cmd(make_cmd(CMD_SET_COLOR, 8'hFF, 8'hFE, 8'h63, 1'b0));
   endtask

   task automatic test_chain_length();
      set_config(8'd99, 8'd0, 8'd0, 8'd0);
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));
      // A length above the maximum is clamped, and bit 7 of the data is dropped.
      set_config(8'd50, 8'hFF, 8'd0, 8'd0);
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));
      set_config(8'd100, 8'h80, 8'd0, 8'd0);
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));
   endtask

   task automatic test_skips();
      set_config(8'd100, 8'd8, 8'd2, 8'd3);
      send_cmd(make_cmd(CMD_SET_COLOR, 8'h12, 8'h34, 8'h56, 1'b0));
      set_config(8'd100, 8'd8, 8'd4, 8'd4);
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));
      set_config(8'd100, 8'd64, 8'd64, 8'd64);
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));
      set_config(8'd100, 8'd8, 8'd7, 8'd0);
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0));
   endtask

   task automatic test_enable();
      // Skips stay set here: the dark frame ignores them.
      set_config(8'd100, 8'd6, 8'd1, 8'd1);
      send_cmd(make_cmd(CMD_SET_ENABLE, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_cmd(make_cmd(CMD_SET_ENABLE, 8'h00, 8'h00, 8'h00, 1'b0));
      send_cmd(make_cmd(CMD_SET_COLOR, 8'hAA, 8'h55, 8'hF0, 1'b0));
      send_cmd(make_cmd(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1'b1));
      send_cmd(make_cmd(CMD_SET_ENABLE, 8'h00, 8'h00, 8'h00, 1'b1));
      send_cmd(make_cmd(CMD_SET_ENABLE, 8'h00, 8'h00, 8'h00, 1'b1));
      send_cmd(make_cmd(CMD_RESERVED, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      set_config(8'd0, 8'd5, 8'd0, 8'd0);
      send_cmd(make_cmd(CMD_SET_ENABLE, 8'h00, 8'h00, 8'h00, 1'b0));
      send_cmd(make_cmd(CMD_SET_ENABLE, 8'h00, 8'h00, 8'h00, 1'b1));
   endtask

   function automatic req_type random_item();
      req_type item;
      int r;
      r = $urandom_range(0, 99);
      item.command = (r < 40) ? CMD_SET_COLOR : (r < 65) ? CMD_SET_ENABLE :
                     (r < 90) ? CMD_REFRESH : CMD_RESERVED;
      item.red = 8'($urandom_range(0, 255));
      item.green = 8'($urandom_range(0, 255));
      item.blue = 8'($urandom_range(0, 255));
      // Mostly request a change of state so enable transitions happen often.
      item.enable_value = ($urandom_range(0, 99) < 70) ? !lit : lit;
      return item;
   endfunction

   task automatic test_random();
      logic [7:0] bright;
      logic [7:0] chain;
      logic [7:0] skip_a;
      logic [7:0] skip_b;
      int counted;
      int r;
      req_type item;
      for (int phase = 0; phase < 7; phase++) begin
         r = $urandom_range(0, 9);
         bright = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'd1 : (r == 3) ? 8'd100 :
                  (r < 6) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 100));
         r = $urandom_range(0, 9);
         chain = (r == 0) ? 8'd0 : (r == 1) ? 8'd64 : (r == 2) ? 8'd127 :
                 (r == 3) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 12));
         r = $urandom_range(0, 9);
         if (r == 0) begin
            skip_a = 8'($urandom_range(0, 255));
            skip_b = 8'($urandom_range(0, 255));
         end else if (r == 1) begin
            skip_a = 8'd64;
            skip_b = 8'd0;
         end else begin
            skip_a = 8'($urandom_range(0, 3));
            skip_b = 8'($urandom_range(0, 3));
         end
         if (phase == 6) bright = 8'd255;
         set_config(bright, chain, skip_a, skip_b);
         idle_on = (phase % 3 != 0);
         stall_on = (phase % 3 != 0) || (phase == 3);
         counted = 0;
         while (counted < 33) begin
            item = random_item();
            send_cmd(item);
            if (item.command != CMD_RESERVED) counted++;
         end
      end
      idle_on = 0;
      stall_on = 0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_BRIGHTNESS;
      csr_wdata <= '0;
      cfg_bright = BRIGHT_RESET;
      cfg_chain = CHAIN_RESET;
      cfg_skip_first = '0;
      cfg_skip_last = '0;
      lit = 1'b1;
      color_r = '0;
      color_g = '0;
      color_b = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      idle_on = 1;
      stall_on = 1;
      test_brightness();
      test_chain_length();
      idle_on = 0;
      test_skips();
      idle_on = 1;
      test_enable();
      test_random();
      settle();
      if (words_due.size() != 0) note_error($sformatf("%0d words never arrived",
                                                      words_due.size()));

      $display("Sent %0d commands under %0d register settings; checked %0d words in %0d frames.",
               commands_sent, settings_used, words_seen, frames_seen);
      $display("Brightness, length and skip extremes, enable transitions, stalls on both sides.");
      if (mismatches == 0) begin
         $display("PASS led_chain_frame_fill");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL led_chain_frame_fill");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Timed out with %0d words outstanding.", words_due.size());
      $display("FAIL led_chain_frame_fill");
      $finish;
   end

endmodule
